[rtl/b64d_pkg.sv]
// Package for the base64 stream decoder: result kinds, character classes,
// queue entry type and the character lookup function.
// No dependencies.
package b64d_pkg;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_INVALID  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    // class codes above the 6-bit value range
    localparam logic [6:0] CODE_SKIP = 7'd64;
    localparam logic [6:0] CODE_PAD  = 7'd65;
    localparam logic [6:0] CODE_BAD  = 7'd66;

    // work for the back end: up to three data bytes, then an optional final result
    typedef struct packed {
        logic [1:0]       n_data;
        logic [2:0][7:0]  bytes;      // bytes[0] goes out first
        logic             has_final;
        kind_t            final_kind;
        logic [15:0]      final_count;
    } entry_t;

    function automatic logic [6:0] classify(input logic [7:0] ch);
        logic [6:0] code;
        code = CODE_BAD;
        if (ch >= 8'd65 && ch <= 8'd90) begin
            code = 7'(ch - 8'd65);
        end else if (ch >= 8'd97 && ch <= 8'd122) begin
            code = 7'(ch - 8'd71);
        end else if (ch >= 8'd48 && ch <= 8'd57) begin
            code = 7'(ch + 8'd4);
        end else if (ch == 8'd43) begin
            code = 7'd62;
        end else if (ch == 8'd47) begin
            code = 7'd63;
        end else if (ch == 8'd10) begin
            code = CODE_SKIP;
        end else if (ch == 8'd61) begin
            code = CODE_PAD;
        end
        return code;
    endfunction

endpackage

[rtl/b64d_if.sv]
// Handshake channels of the base64 stream decoder: encoded input,
// decoded results and the capacity register write.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_message;
    modport source (output valid, output char_in, output end_of_message, input ready);
    modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last;
    modport source (output valid, output kind, output data_byte, output byte_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_count,
                    input last, output ready);
endinterface

interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] output_capacity;
    modport source (output valid, output output_capacity, input ready);
    modport sink   (input valid, input output_capacity, output ready);
endinterface

[rtl/b64d_queue.sv]
// Small register FIFO of decoder work entries between front and back end.
// Uses b64d_pkg::entry_t.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output b64d_pkg::entry_t  head_entry
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/b64d_front.sv]
// Front end: takes encoded characters, classifies them, keeps the message
// state and capacity register, and pushes result work to the queue. Uses b64d_pkg.
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    b64d_in_if.sink           enc,
    b64d_cfg_if.sink          cfg,
    input  logic              q_full,
    output logic              q_push,
    output b64d_pkg::entry_t  q_entry
);
    logic [15:0] cap_reg;
    logic [17:0] sbuf_reg, sbuf_next;
    logic [1:0]  scnt_reg, scnt_next;
    logic [15:0] bw_reg, bw_next;
    logic        pad_reg, pad_next;
    logic        abort_reg, abort_next;

    logic        accept;
    logic [6:0]  code;
    logic [23:0] word;
    logic        fin;
    b64d_pkg::entry_t ent;

    assign enc.ready = !q_full;
    assign cfg.ready = 1'b1;
    assign accept    = enc.valid && !q_full;
    assign code      = b64d_pkg::classify(enc.char_in);
    assign word      = {sbuf_reg, code[5:0]};

    always_comb
    begin
        sbuf_next  = sbuf_reg;
        scnt_next  = scnt_reg;
        bw_next    = bw_reg;
        pad_next   = pad_reg;
        abort_next = abort_reg;
        fin        = 1'b0;
        ent             = '0;
        ent.final_kind  = b64d_pkg::KIND_DONE;

        if (abort_reg)
        begin
            fin = 1'b1;   // silent; message state clears on the end marker
        end
        else if (!pad_reg && code == b64d_pkg::CODE_BAD)
        begin
            ent.has_final  = 1'b1;
            ent.final_kind = b64d_pkg::KIND_INVALID;
            abort_next     = 1'b1;
            fin            = 1'b1;
        end
        else if (!pad_reg && code == b64d_pkg::CODE_PAD)
        begin
            pad_next = 1'b1;
        end
        else if (!pad_reg && code != b64d_pkg::CODE_SKIP)
        begin
            if (scnt_reg == 2'd3)
            begin
                if ({1'b0, bw_reg} + 17'd3 > {1'b0, cap_reg})
                begin
                    ent.has_final  = 1'b1;
                    ent.final_kind = b64d_pkg::KIND_OVERFLOW;
                    abort_next     = 1'b1;
                    fin            = 1'b1;
                end
                else
                begin
                    ent.n_data   = 2'd3;
                    ent.bytes[0] = word[23:16];
                    ent.bytes[1] = word[15:8];
                    ent.bytes[2] = word[7:0];
                    bw_next      = bw_reg + 16'd3;
                    sbuf_next    = '0;
                    scnt_next    = 2'd0;
                end
            end
            else
            begin
                sbuf_next = {sbuf_reg[11:0], code[5:0]};
                scnt_next = scnt_reg + 2'd1;
            end
        end

        // end of message: flush the partial group and report
        if (!fin && enc.end_of_message)
        begin
            ent.has_final = 1'b1;
            if (scnt_next == 2'd3)
            begin
                if ({1'b0, bw_next} + 17'd2 > {1'b0, cap_reg})
                begin
                    ent.final_kind = b64d_pkg::KIND_OVERFLOW;
                end
                else
                begin
                    ent.n_data      = 2'd2;
                    ent.bytes[0]    = sbuf_next[17:10];
                    ent.bytes[1]    = sbuf_next[9:2];
                    ent.final_count = bw_next + 16'd2;
                end
            end
            else if (scnt_next == 2'd2)
            begin
                if ({1'b0, bw_next} + 17'd1 > {1'b0, cap_reg})
                begin
                    ent.final_kind = b64d_pkg::KIND_OVERFLOW;
                end
                else
                begin
                    ent.n_data      = 2'd1;
                    ent.bytes[0]    = sbuf_next[11:4];
                    ent.final_count = bw_next + 16'd1;
                end
            end
            else
            begin
                ent.final_count = bw_next;
            end
        end

        if (enc.end_of_message)
        begin
            sbuf_next  = '0;
            scnt_next  = 2'd0;
            bw_next    = '0;
            pad_next   = 1'b0;
            abort_next = 1'b0;
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.has_final || ent.n_data != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 16'hFFFF;
            sbuf_reg  <= '0;
            scnt_reg  <= '0;
            bw_reg    <= '0;
            pad_reg   <= 1'b0;
            abort_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.output_capacity;
            end
            if (accept)
            begin
                sbuf_reg  <= sbuf_next;
                scnt_reg  <= scnt_next;
                bw_reg    <= bw_next;
                pad_reg   <= pad_next;
                abort_reg <= abort_next;
            end
        end
    end

endmodule

[rtl/b64d_back.sv]
// Back end: walks each queued entry and loads one result per cycle, while dec is
// ready or the output register is empty, into the output register. Uses b64d_pkg.
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64d_pkg::entry_t  head_entry,
    output logic              pop,
    b64d_out_if.source        dec
);
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] count_reg;
    logic        last_reg;
    logic [1:0]  idx_reg, idx_next;

    logic        load;
    logic [2:0]  total;
    logic        is_data;
    logic        end_of_entry;
    logic [1:0]  kind_next;
    logic [7:0]  byte_next;
    logic [15:0] count_next;

    assign load    = head_valid && (!valid_reg || dec.ready);
    assign total   = {1'b0, head_entry.n_data} + {2'b00, head_entry.has_final};
    assign is_data = (idx_reg < head_entry.n_data);
    assign end_of_entry = ({1'b0, idx_reg} + 3'd1 == total);
    assign pop     = load && end_of_entry;
    assign idx_next = end_of_entry ? 2'd0 : idx_reg + 2'd1;

    always_comb
    begin
        kind_next  = head_entry.final_kind;
        byte_next  = '0;
        count_next = '0;
        if (is_data)
        begin
            kind_next = b64d_pkg::KIND_DATA;
            byte_next = head_entry.bytes[idx_reg];
        end
        else if (head_entry.final_kind == b64d_pkg::KIND_DONE)
        begin
            count_next = head_entry.final_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (dec.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            count_reg <= count_next;
            last_reg  <= !is_data;
        end
    end

    assign dec.valid      = valid_reg;
    assign dec.kind       = kind_reg;
    assign dec.data_byte  = byte_reg;
    assign dec.byte_count = count_reg;
    assign dec.last       = last_reg;

endmodule

[rtl/base64_stream_decoder_unit.sv]
// Base64 stream decoder, top level: front end, work queue, back end.
// The results of a character pass through the work queue and then the output register on their way to dec.
// Throughput: one character per cycle while the work queue has room; the output
// register drains one result per cycle while dec is ready.
// Reset (rst_n, async): message state and queue cleared, capacity set to 65535.
// Depends on b64d_pkg, b64d_if, b64d_queue, b64d_front, b64d_back.
module base64_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    b64d_in_if.sink     enc,
    b64d_cfg_if.sink    cfg,
    b64d_out_if.source  dec
);
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    b64d_pkg::entry_t q_in;
    b64d_pkg::entry_t q_head;

    b64d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .enc     (enc),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .dec        (dec)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full work queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty work queue");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid |-> (dec.last == (dec.kind != b64d_pkg::KIND_DATA)))
        else $error("last flag does not match result kind");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.valid && dec.kind != b64d_pkg::KIND_DONE) |-> (dec.byte_count == 16'd0))
        else $error("byte count set on a result that is not done");

endmodule
